### sv/dmsc_pkg.sv
`timescale 1ns / 1ps

package dmsc_pkg;

	localparam int LINES    = 64;
	localparam int LINE_W   = $clog2(LINES);
	localparam int SECTOR_W = 23;
	localparam int TAG_W    = SECTOR_W - LINE_W;
	localparam int IDX_W    = 6;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	typedef struct packed {
		logic [1:0]          op;
		logic [SECTOR_W-1:0] sector;
	} dmsc_req_t;

	typedef struct packed {
		logic                hit;
		logic                writeback_valid;
		logic [SECTOR_W-1:0] writeback_sector;
		logic                fetch_valid;
		logic [IDX_W-1:0]    line_index;
		logic                last;
	} dmsc_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ACC  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_EMIT = 4'b1000
	} dmsc_state_t;

endpackage

### sv/dmsc_tag_mem.sv
`timescale 1ns / 1ps

module dmsc_tag_mem
	import dmsc_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [LINE_W-1:0] wr_addr,
	input  logic [TAG_W-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [LINE_W-1:0] rd_addr,
	output logic [TAG_W-1:0]  rd_data
);

	logic [TAG_W-1:0] mem [LINES];
	logic [TAG_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### sv/dmsc_tag_unit.sv
`timescale 1ns / 1ps

module dmsc_tag_unit
	import dmsc_pkg::*;
(
	input  logic [LINE_W-1:0]   line,
	input  logic [TAG_W-1:0]    stored_tag,
	input  logic [TAG_W-1:0]    probe_tag,
	output logic                tag_eq,
	output logic [SECTOR_W-1:0] line_sector
);

	// shared by access compare and flush writeback
	assign tag_eq      = (stored_tag == probe_tag);
	assign line_sector = {stored_tag, line};

endmodule

### sv/direct_mapped_sector_cache_tags.sv
`timescale 1ns / 1ps

// Tag and state controller of a direct-mapped write-back sector cache with LINES lines
// (a power of two). A read or write request is taken while idle and its single response
// is formed in the compare state from the registered tag memory read; no new request is
// taken until that response is loaded. A flush scans the lines in order, passing clean
// lines and emitting a writeback for each dirty line up to the last dirty line; with no
// dirty line it gives one response with last set. Responses sit in an output register, and
// a new request is taken while one waits there. Op code 3 is taken with no response.
module direct_mapped_sector_cache_tags
	import dmsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  dmsc_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output dmsc_rsp_t rsp
);

	dmsc_state_t         state_q;
	dmsc_req_t           req_q;
	logic [LINE_W-1:0]   idx_q;
	logic [LINES-1:0]    valid_q;
	logic [LINES-1:0]    dirty_q;
	dmsc_rsp_t           rsp_q;
	logic                rsp_valid_q;

	logic                req_fire;
	logic                out_free;
	logic                rsp_load;
	logic                rd_en;
	logic [LINE_W-1:0]   rd_addr;
	logic [TAG_W-1:0]    rd_tag;
	logic [LINE_W-1:0]   acc_line;
	logic [TAG_W-1:0]    acc_tag;
	logic [LINE_W-1:0]   unit_line;
	logic                tag_eq;
	logic [SECTOR_W-1:0] unit_sector;
	logic                acc_hit;
	logic                acc_wb;
	logic                mem_we;
	logic                more_dirty;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_load  = out_free && ((state_q == ST_ACC) || (state_q == ST_EMIT) ||
		(state_q == ST_SCAN && !(|dirty_q)));

	assign acc_line = req_q.sector[LINE_W-1:0];
	assign acc_tag  = req_q.sector[SECTOR_W-1:LINE_W];

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		if (state_q == ST_IDLE) begin
			rd_en   = req_fire;
			rd_addr = req.sector[LINE_W-1:0];
		end else if (state_q == ST_SCAN) begin
			rd_en   = dirty_q[idx_q];
		end
	end

	assign unit_line  = (state_q == ST_ACC) ? acc_line : idx_q;
	assign acc_hit    = valid_q[acc_line] && tag_eq;
	assign acc_wb     = !acc_hit && valid_q[acc_line] && dirty_q[acc_line];
	assign mem_we     = (state_q == ST_ACC) && out_free && !acc_hit;
	assign more_dirty = |((dirty_q >> idx_q) >> 1);

	dmsc_tag_mem u_tag_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (acc_line),
		.wr_data (acc_tag),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_tag)
	);

	dmsc_tag_unit u_tag_unit (
		.line        (unit_line),
		.stored_tag  (rd_tag),
		.probe_tag   (acc_tag),
		.tag_eq      (tag_eq),
		.line_sector (unit_sector)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			valid_q     <= '0;
			dirty_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.op == OP_FLUSH) begin
							idx_q   <= '0;
							state_q <= ST_SCAN;
						end else if (req.op == OP_READ || req.op == OP_WRITE) begin
							state_q <= ST_ACC;
						end
					end
				end
				ST_ACC: begin
					if (out_free) begin
						if (!acc_hit) begin
							valid_q[acc_line] <= 1'b1;
							dirty_q[acc_line] <= (req_q.op == OP_WRITE);
						end else if (req_q.op == OP_WRITE) begin
							dirty_q[acc_line] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (!(|dirty_q)) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end else if (dirty_q[idx_q]) begin
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						dirty_q[idx_q] <= 1'b0;
						if (more_dirty) begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req;
		end
		if (out_free) begin
			if (state_q == ST_ACC) begin
				rsp_q.hit              <= acc_hit;
				rsp_q.writeback_valid  <= acc_wb;
				rsp_q.writeback_sector <= acc_wb ? unit_sector : '0;
				rsp_q.fetch_valid      <= !acc_hit;
				rsp_q.line_index       <= IDX_W'(acc_line);
				rsp_q.last             <= 1'b1;
			end else if (state_q == ST_EMIT) begin
				rsp_q.hit              <= 1'b0;
				rsp_q.writeback_valid  <= 1'b1;
				rsp_q.writeback_sector <= unit_sector;
				rsp_q.fetch_valid      <= 1'b0;
				rsp_q.line_index       <= IDX_W'(idx_q);
				rsp_q.last             <= !more_dirty;
			end else if (state_q == ST_SCAN && !(|dirty_q)) begin
				rsp_q.hit              <= 1'b0;
				rsp_q.writeback_valid  <= 1'b0;
				rsp_q.writeback_sector <= '0;
				rsp_q.fetch_valid      <= 1'b0;
				rsp_q.line_index       <= '0;
				rsp_q.last             <= 1'b1;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### sv/dmsc_checker.sv
`timescale 1ns / 1ps

module dmsc_checker
	import dmsc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input dmsc_req_t req,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input dmsc_rsp_t rsp
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// a hit moves nothing
	a_hit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> !rsp.fetch_valid && !rsp.writeback_valid && rsp.last)
		else $error("hit with writeback or fetch");

	a_wb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.writeback_valid |-> rsp.writeback_sector == '0)
		else $error("writeback sector set without writeback");

	// an access keeps the block busy in its compare state
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.op == OP_READ || req.op == OP_WRITE) |=> !req_ready)
		else $error("request taken during access compare");

endmodule

bind direct_mapped_sector_cache_tags dmsc_checker u_dmsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

### tb/direct_mapped_sector_cache_tags_tb.sv
`timescale 1ns / 1ps

module direct_mapped_sector_cache_tags_tb
	import dmsc_pkg::*;
;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_PER_PHASE = 67;
	localparam int TAIL_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 4000;

	class sector_cache_scoreboard;
		logic [TAG_W-1:0] tag_mem [LINES];
		bit valid_bits [LINES];
		bit dirty_bits [LINES];
		dmsc_rsp_t pending [$];
		int errors;
		int checked;
		int hits;
		int misses;
		int writebacks;
		int flushes;

		function new();
			for (int i = 0; i < LINES; i++) begin
				tag_mem[i] = '0;
				valid_bits[i] = 1'b0;
				dirty_bits[i] = 1'b0;
			end
			errors = 0;
			checked = 0;
			hits = 0;
			misses = 0;
			writebacks = 0;
			flushes = 0;
		endfunction

		function void note_request(dmsc_req_t r);
			dmsc_rsp_t e;
			logic [LINE_W-1:0] ln;
			logic [TAG_W-1:0] tg;
			int first;
			int i;
			e = '0;
			case (r.op)
				OP_FLUSH: begin
					flushes++;
					first = pending.size();
					for (i = 0; i < LINES; i++) begin
						if (dirty_bits[i]) begin
							ln = i[LINE_W-1:0];
							e = '0;
							e.writeback_valid = 1'b1;
							e.writeback_sector = {tag_mem[i], ln};
							e.line_index = ln;
							pending.push_back(e);
							dirty_bits[i] = 1'b0;
							writebacks++;
						end
					end
					if (pending.size() == first) begin
						e = '0;
						e.last = 1'b1;
						pending.push_back(e);
					end else begin
						pending[pending.size()-1].last = 1'b1;
					end
				end
				OP_READ, OP_WRITE: begin
					ln = r.sector[LINE_W-1:0];
					tg = r.sector[SECTOR_W-1:LINE_W];
					e.line_index = ln;
					e.last = 1'b1;
					if (valid_bits[ln] && tag_mem[ln] == tg) begin
						e.hit = 1'b1;
						hits++;
					end else begin
						if (valid_bits[ln] && dirty_bits[ln]) begin
							e.writeback_valid = 1'b1;
							e.writeback_sector = {tag_mem[ln], ln};
							writebacks++;
						end
						e.fetch_valid = 1'b1;
						tag_mem[ln] = tg;
						valid_bits[ln] = 1'b1;
						dirty_bits[ln] = 1'b0;
						misses++;
					end
					if (r.op == OP_WRITE) begin
						dirty_bits[ln] = 1'b1;
					end
					pending.push_back(e);
				end
				default: begin
				end
			endcase
		endfunction

		function void check_response(dmsc_rsp_t got);
			dmsc_rsp_t want;
			if (pending.size() == 0) begin
				$error("response with no request outstanding: %p", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.hit !== want.hit) begin
				$error("hit: expected %0h, got %0h", want.hit, got.hit);
				errors++;
			end
			if (got.writeback_valid !== want.writeback_valid) begin
				$error("writeback_valid: expected %0h, got %0h",
					want.writeback_valid, got.writeback_valid);
				errors++;
			end
			if (got.writeback_sector !== want.writeback_sector) begin
				$error("writeback_sector: expected %0h, got %0h",
					want.writeback_sector, got.writeback_sector);
				errors++;
			end
			if (got.fetch_valid !== want.fetch_valid) begin
				$error("fetch_valid: expected %0h, got %0h", want.fetch_valid, got.fetch_valid);
				errors++;
			end
			if (got.line_index !== want.line_index) begin
				$error("line_index: expected %0h, got %0h", want.line_index, got.line_index);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0h, got %0h", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	dmsc_req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	dmsc_rsp_t rsp;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int sent = 0;

	sector_cache_scoreboard sb = new();

	direct_mapped_sector_cache_tags uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			sb.check_response(rsp);
		end
		if (req_valid && req_ready) begin
			sb.note_request(req);
		end
	end

	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				stall = 0;
			end else begin
				stall++;
			end
		end
		$display("Test completed with failures");
		$finish;
	end

	// entered and left at a falling edge
	task automatic send_request(input logic [1:0] op, input logic [SECTOR_W-1:0] sector);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		req <= '{op: op, sector: sector};
		req_valid <= 1'b1;
		sent++;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(negedge clk); while (sb.pending.size() != 0);
	endtask

	initial begin
		int phase;
		int n;
		int pick;
		logic [1:0] op;
		logic [SECTOR_W-1:0] sec;
		logic [TAG_W-1:0] hot_tags [4];

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 34;
		recv_idle_pct = 77;

		// directed requests
		send_request(OP_READ, 23'd0);
		send_request(OP_READ, 23'd0);
		send_request(OP_WRITE, 23'd0);
		send_request(OP_FLUSH, 23'd0);
		send_request(OP_FLUSH, 23'h7fffff);
		send_request(OP_WRITE, 23'h7fffff);
		send_request(OP_WRITE, 23'd63);
		send_request(OP_READ, 23'h7fffff);
		send_request(OP_WRITE, 23'd1);
		send_request(OP_WRITE, 23'd62);
		send_request(OP_UNUSED, 23'h7fffff);
		send_request(OP_FLUSH, 23'd0);
		send_request(OP_WRITE, {{TAG_W{1'b1}}, 6'd5});
		send_request(OP_READ, {{TAG_W{1'b1}}, 6'd5});
		send_request(OP_WRITE, 23'h555555);
		send_request(OP_WRITE, 23'h2aaaaa);
		send_request(OP_UNUSED, 23'd0);
		send_request(OP_FLUSH, 23'h2aaaaa);
		send_request(OP_READ, 23'h2aaaaa);
		send_request(OP_READ, 23'h555555);
		wait_drained();

		hot_tags[0] = '0;
		hot_tags[1] = '1;
		hot_tags[2] = TAG_W'($urandom);
		hot_tags[3] = TAG_W'($urandom);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 34;
					recv_idle_pct = 77;
				end
				1: begin
					send_idle_pct = 77;
					recv_idle_pct = 34;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 4) begin
					op = OP_FLUSH;
				end else if (pick < 7) begin
					op = OP_UNUSED;
				end else if (pick < 52) begin
					op = OP_READ;
				end else begin
					op = OP_WRITE;
				end
				if ($urandom_range(0, 9) < 3) begin
					sec = SECTOR_W'($urandom);
				end else begin
					sec = {hot_tags[$urandom_range(0, 3)], LINE_W'($urandom_range(0, 15))};
				end
				send_request(op, sec);
				if ($urandom_range(0, 39) == 0) begin
					wait_drained();
				end
			end
			wait_drained();
		end

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests, %0d responses checked: %0d hits, %0d misses,",
			sent, sb.checked, sb.hits, sb.misses);
		$display("%0d writebacks, %0d flushes, across three sender/receiver pacing phases",
			sb.writebacks, sb.flushes);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
